FILE: rtl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
`default_nettype none
package bpa_pkg;

   localparam int MARK_W = 4;
   localparam int POOL_W = 11;
   localparam int PAGE_W = 10;
   localparam int STAT_W = 2;

   typedef logic [MARK_W-1:0] mark_type;

   localparam mark_type MARK_NONE  = 4'd0;
   localparam mark_type MARK_LEFT  = 4'd1;
   localparam mark_type MARK_RIGHT = 4'd2;
   localparam mark_type MARK_FULL  = 4'd4;
   localparam mark_type MARK_OUT   = 4'd8;

   localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOFIT    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/buddy_page_allocator.sv
// Buddy page allocator top level: request sequencer over the node mark memory.
//
//  channel | ports                                     | direction
//  req     | req_valid/ready, mode, request_pages, idx | in
//  rsp     | rsp_valid/ready, status, page, pages      | out
//  csr     | csr_wen, csr_wdata (pool_pages)           | in
//
// One memory port does all mark reads; a request walks the tree node by node.
// Allocate: each node visited going down is read, then checked; backtrack
// steps follow; climbing to the root reads sibling and parent per level and
// writes the parent mark. Free: walks up to find the owner, then clears full
// bits and side bits upward. Reset and every pool_pages write rebuild the
// marks with req_ready low. One request in flight; req_ready stays low until
// the response transfer.
`default_nettype none
module buddy_page_allocator
   import bpa_pkg::*;
#(
   parameter int ROOT_PAGES = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_mode,
   input  wire logic [POOL_W-1:0] req_request_pages,
   input  wire logic [PAGE_W-1:0] req_page_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [PAGE_W-1:0]      rsp_granted_page,
   output logic [POOL_W-1:0]      rsp_granted_pages,
   input  wire logic              csr_wen,
   input  wire logic [POOL_W-1:0] csr_wdata
);

   localparam int LW = $clog2(ROOT_PAGES);
   localparam int NW = LW + 1;
   localparam int SW = LW + 1;
   localparam int CW = ((SW > POOL_W) ? SW : POOL_W) + 1;
   localparam logic [SW-1:0] ROOT_SIZE = SW'(ROOT_PAGES);
   localparam logic [NW-1:0] ROOT_NODE = NW'(1);

   typedef enum logic [3:0] {
      ST_BUILD, ST_IDLE,
      ST_A_RD, ST_A_CHK, ST_A_BACK, ST_A_SIB, ST_A_PAR, ST_A_WR,
      ST_F_RD, ST_F_CHK, ST_F_CLR_RD, ST_F_CLR_WR, ST_F_TURN,
      ST_F_SIDE_RD, ST_F_SIDE_WR
   } state_type;

   state_type          state_ff, state_in;
   logic [NW-1:0]      n_ff, n_in, own_ff, own_in;
   logic [SW-1:0]      size_ff, size_in;
   logic [LW-1:0]      start_ff, start_in;
   logic [POOL_W-1:0]  want_ff, want_in, pool_ff;
   mark_type           cm_ff, cm_in;
   logic               sib_ff, sib_in, odd_ff, odd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]  rsp_page_ff, rsp_page_in;
   logic [POOL_W-1:0]  rsp_pages_ff, rsp_pages_in;

   logic               b_busy, b_wr_en;
   logic [NW-1:0]      b_wr_addr;
   mark_type           b_wr_data;
   logic               f_wr_en;
   logic [NW-1:0]      f_wr_addr, rd_addr;
   mark_type           f_wr_data, rd_data, pm, side;
   logic [NW-1:0]      parent;
   logic               at_level;

   bpa_tree_build #(.ROOT_PAGES(ROOT_PAGES)) u_build (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_wen),
      .pool_pages (pool_ff),
      .busy       (b_busy),
      .wr_en      (b_wr_en),
      .wr_addr    (b_wr_addr),
      .wr_data    (b_wr_data)
   );

   bpa_mark_ram #(.AW(NW)) u_ram (
      .clock   (clock),
      .wr_en   (b_wr_en || f_wr_en),
      .wr_addr (b_busy ? b_wr_addr : f_wr_addr),
      .wr_data (b_busy ? b_wr_data : f_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      own_in        = own_ff;
      size_in       = size_ff;
      start_in      = start_ff;
      want_in       = want_ff;
      cm_in         = cm_ff;
      sib_in        = sib_ff;
      odd_in        = odd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_pages_in  = rsp_pages_ff;
      rd_addr       = n_ff;
      f_wr_en       = 1'b0;
      f_wr_addr     = n_ff;
      f_wr_data     = MARK_NONE;
      parent        = n_ff >> 1;
      side          = n_ff[0] ? MARK_RIGHT : MARK_LEFT;
      pm            = MARK_NONE;
      at_level      = (size_ff == SW'(1)) || (CW'(size_ff >> 1) < CW'(want_ff));

      case (state_ff)
         ST_BUILD: begin
            if (!b_busy) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_status_in = STAT_DONE;
               rsp_page_in   = '0;
               rsp_pages_in  = '0;
               if (req_mode == MODE_ALLOC) begin
                  want_in  = req_request_pages;
                  n_in     = ROOT_NODE;
                  size_in  = ROOT_SIZE;
                  start_in = '0;
                  if (req_request_pages == '0 ||
                      CW'(req_request_pages) > CW'(ROOT_SIZE)) begin
                     rsp_status_in = STAT_NOFIT;
                     rsp_valid_in  = 1'b1;
                  end else begin
                     state_in = ST_A_RD;
                  end
               end else begin
                  n_in     = {1'b1, LW'(req_page_index)};
                  odd_in   = 1'b0;
                  state_in = ST_F_RD;
               end
            end
         end
         ST_A_RD: begin
            state_in = ST_A_CHK;
         end
         ST_A_CHK: begin
            if ((rd_data & MARK_FULL) != MARK_NONE) begin
               state_in = ST_A_BACK;
            end else if (at_level) begin
               if (rd_data == MARK_NONE) begin
                  f_wr_en   = 1'b1;
                  f_wr_data = MARK_FULL;
                  cm_in     = MARK_FULL;
                  if (n_ff == ROOT_NODE) begin
                     rsp_page_in  = PAGE_W'(start_ff);
                     rsp_pages_in = POOL_W'(size_ff);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_A_SIB;
                  end
               end else begin
                  state_in = ST_A_BACK;
               end
            end else begin
               n_in     = n_ff << 1;
               size_in  = size_ff >> 1;
               state_in = ST_A_RD;
            end
         end
         ST_A_BACK: begin
            // climb out of right children, then step to the right sibling
            if (n_ff == ROOT_NODE) begin
               rsp_status_in = STAT_NOFIT;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else if (n_ff[0]) begin
               n_in     = parent;
               start_in = start_ff - LW'(size_ff);
               size_in  = size_ff << 1;
            end else begin
               n_in     = n_ff | NW'(1);
               start_in = start_ff + LW'(size_ff);
               state_in = ST_A_RD;
            end
         end
         ST_A_SIB: begin
            rd_addr  = n_ff ^ NW'(1);
            state_in = ST_A_PAR;
         end
         ST_A_PAR: begin
            sib_in   = (rd_data & MARK_FULL) != MARK_NONE;
            rd_addr  = parent;
            state_in = ST_A_WR;
         end
         ST_A_WR: begin
            pm = rd_data | side;
            if (((cm_ff & MARK_FULL) != MARK_NONE) && sib_ff) pm = pm | MARK_FULL;
            f_wr_en   = 1'b1;
            f_wr_addr = parent;
            f_wr_data = pm;
            cm_in     = pm;
            n_in      = parent;
            if (parent == ROOT_NODE) begin
               rsp_page_in  = PAGE_W'(start_ff);
               rsp_pages_in = POOL_W'(size_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_A_SIB;
            end
         end
         ST_F_RD: begin
            if (n_ff == '0) begin
               rsp_status_in = STAT_MISMATCH;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (rd_data == MARK_NONE && !odd_ff) begin
               odd_in   = n_ff[0];
               n_in     = parent;
               state_in = ST_F_RD;
            end else if (rd_data == MARK_FULL) begin
               own_in   = n_ff;
               state_in = ST_F_CLR_RD;
            end else begin
               rsp_status_in = STAT_MISMATCH;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_F_CLR_RD: begin
            state_in = ST_F_CLR_WR;
         end
         ST_F_CLR_WR: begin
            f_wr_en   = 1'b1;
            f_wr_data = rd_data & ~MARK_FULL;
            if (n_ff == ROOT_NODE) begin
               n_in     = own_ff;
               state_in = ST_F_TURN;
            end else begin
               n_in     = parent;
               state_in = ST_F_CLR_RD;
            end
         end
         ST_F_TURN: begin
            // lets the root write land before the side-bit pass reads it
            state_in = ST_F_SIDE_RD;
         end
         ST_F_SIDE_RD: begin
            rd_addr = parent;
            if (n_ff == ROOT_NODE) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_F_SIDE_WR;
            end
         end
         ST_F_SIDE_WR: begin
            pm        = rd_data & ~side;
            f_wr_en   = 1'b1;
            f_wr_addr = parent;
            f_wr_data = pm;
            n_in      = parent;
            if (pm != MARK_NONE || parent == ROOT_NODE) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_F_SIDE_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wen) state_in = ST_BUILD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BUILD;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= POOL_W'(1024);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) pool_ff <= csr_wdata;
      end
      n_ff          <= n_in;
      own_ff        <= own_in;
      size_ff       <= size_in;
      start_ff      <= start_in;
      want_ff       <= want_in;
      cm_ff         <= cm_in;
      sib_ff        <= sib_in;
      odd_ff        <= odd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_pages_ff  <= rsp_pages_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_page  = rsp_page_ff;
   assign rsp_granted_pages = rsp_pages_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a second request while one is in flight");

   a_pow2_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_granted_pages))
      else $error("granted size is not a power of two");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_DONE) |->
         (rsp_granted_pages == '0 && rsp_granted_page == '0))
      else $error("failed request carries a grant");

   a_no_req_in_build: assert property (@(posedge clock) disable iff (reset)
      b_busy |-> !req_ready)
      else $error("request taken during tree rebuild");

endmodule
`default_nettype wire

FILE: rtl/bpa_mark_ram.sv
// Node mark memory: one write port, one registered read port.
`default_nettype none
module bpa_mark_ram
   import bpa_pkg::*;
#(
   parameter int AW = 11
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire mark_type      wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output mark_type           rd_data
);

   mark_type mem [2**AW];
   mark_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/bpa_tree_build.sv
// Sweep that rewrites every node mark from the pool size, one node a cycle.
`default_nettype none
module bpa_tree_build
   import bpa_pkg::*;
#(
   parameter int ROOT_PAGES = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [POOL_W-1:0]              pool_pages,
   output logic                                busy,
   output logic                                wr_en,
   output logic [$clog2(ROOT_PAGES):0]         wr_addr,
   output mark_type                            wr_data
);

   localparam int LW = $clog2(ROOT_PAGES);
   localparam int NW = LW + 1;
   localparam int SW = LW + 1;
   localparam int CW = ((SW > POOL_W) ? SW : POOL_W) + 1;
   localparam logic [SW-1:0] ROOT_SIZE = SW'(ROOT_PAGES);

   logic          busy_ff, busy_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [LW-1:0] start_ff, start_in;
   logic [SW-1:0] size_ff, size_in;
   logic [CW-1:0] end_c, mid_c, pool_c;
   logic          out_node, out_left;
   mark_type      mark_c;

   always_comb begin
      pool_c   = CW'(pool_pages);
      end_c    = CW'(start_ff) + CW'(size_ff);
      mid_c    = CW'(start_ff) + CW'(size_ff >> 1);
      out_node = end_c > pool_c;
      out_left = mid_c > pool_c;
      mark_c   = out_node ? MARK_OUT : MARK_NONE;
      if (size_ff > SW'(1)) begin
         if (out_node) mark_c = mark_c | MARK_RIGHT;
         if (out_left) mark_c = mark_c | MARK_LEFT;
      end

      busy_in  = busy_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      size_in  = size_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = NW'(1);
         start_in = '0;
         size_in  = ROOT_SIZE;
      end else if (busy_ff) begin
         if (idx_ff == '1) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + NW'(1);
            // last node of a level: next level starts at page 0, half size
            if (end_c == CW'(ROOT_SIZE)) begin
               start_in = '0;
               size_in  = size_ff >> 1;
            end else begin
               start_in = start_ff + LW'(size_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         idx_ff   <= NW'(1);
         start_ff <= '0;
         size_ff  <= ROOT_SIZE;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         start_ff <= start_in;
         size_ff  <= size_in;
      end
   end

   assign busy    = busy_ff;
   assign wr_en   = busy_ff && !start;
   assign wr_addr = idx_ff;
   assign wr_data = mark_c;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the buddy page allocator: directed and random traffic vs. a tree predictor.
`default_nettype none
module testbench;
   import bpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROOT = 1024;
   localparam int NODES = 2 * ROOT;

   typedef struct packed {
      logic              mode;
      logic [POOL_W-1:0] pages;
      logic [PAGE_W-1:0] index;
   } page_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] page;
      logic [POOL_W-1:0] pages;
   } grant_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_ALLOC;
   logic [POOL_W-1:0] req_request_pages = '0;
   logic [PAGE_W-1:0] req_page_index = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [PAGE_W-1:0] rsp_granted_page;
   logic [POOL_W-1:0] rsp_granted_pages;
   logic              csr_wen = 1'b0;
   logic [POOL_W-1:0] csr_wdata = '0;

   buddy_page_allocator #(.ROOT_PAGES(ROOT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_request_pages(req_request_pages), .req_page_index(req_page_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_granted_page(rsp_granted_page), .rsp_granted_pages(rsp_granted_pages),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predicted allocator state
   mark_type     tree_marks [NODES];
   int           pool_size = 1024;
   int           live_pages [$];
   page_req_type pending_reqs [$];
   grant_type    expected_grants [$];
   int           mismatches = 0;
   int           n_reqs = 0, n_grants = 0, n_frees = 0, n_rejects = 0;

   function automatic bit build_subtree(int n, int start, int size);
      bit       outside = (start + size) > pool_size;
      mark_type m = outside ? MARK_OUT : MARK_NONE;
      if (size > 1) begin
         if (build_subtree(2 * n, start, size / 2)) begin
            m |= MARK_LEFT;
            outside = 1'b1;
         end
         if (build_subtree(2 * n + 1, start + size / 2, size / 2)) begin
            m |= MARK_RIGHT;
            outside = 1'b1;
         end
      end
      tree_marks[n] = m;
      return outside;
   endfunction

   task automatic rebuild_tree();
      foreach (tree_marks[i]) tree_marks[i] = MARK_NONE;
      void'(build_subtree(1, 0, ROOT));
   endtask

   function automatic int lead_page(int n);
      while (n < ROOT) n *= 2;
      return n - ROOT;
   endfunction

   function automatic int block_size(int n);
      int size = ROOT;
      while (n > 1) begin
         n >>= 1;
         size >>= 1;
      end
      return size;
   endfunction

   function automatic int find_block(int n, int size, int want);
      int hit;
      if (size < want || n >= NODES || (tree_marks[n] & MARK_FULL) != 0) return 0;
      hit = find_block(2 * n, size / 2, want);
      if (hit != 0) return hit;
      hit = find_block(2 * n + 1, size / 2, want);
      if (hit != 0) return hit;
      if (tree_marks[n] == MARK_NONE && lead_page(n) + size <= pool_size) return n;
      return 0;
   endfunction

   function automatic grant_type predict_grant(page_req_type r);
      grant_type g = '0;
      int        n, p, prev, idx;
      if (r.mode == MODE_ALLOC) begin
         n = (r.pages == 0) ? 0 : find_block(1, ROOT, int'(r.pages));
         if (n == 0) begin
            g.status = STAT_NOFIT;
         end else begin
            g.status = STAT_DONE;
            g.page = PAGE_W'(lead_page(n));
            g.pages = POOL_W'(block_size(n));
            live_pages.push_back(lead_page(n));
            tree_marks[n] = MARK_FULL;
            for (; n > 1; n = p) begin
               p = n >> 1;
               tree_marks[p] |= (n & 1) ? MARK_RIGHT : MARK_LEFT;
               if ((tree_marks[n] & MARK_FULL) != 0 && (tree_marks[n ^ 1] & MARK_FULL) != 0)
                  tree_marks[p] |= MARK_FULL;
            end
         end
      end else begin
         n = ROOT + int'(r.index) % ROOT;
         prev = 0;
         while (n > 0 && tree_marks[n] == MARK_NONE && (prev & 1) == 0) begin
            prev = n;
            n >>= 1;
         end
         if (n == 0 || tree_marks[n] != MARK_FULL) begin
            g.status = STAT_MISMATCH;
         end else begin
            g.status = STAT_DONE;
            idx = -1;
            foreach (live_pages[i]) if (idx < 0 && live_pages[i] == lead_page(n)) idx = i;
            if (idx >= 0) live_pages.delete(idx);
            for (p = n; p >= 1; p >>= 1) tree_marks[p] &= ~MARK_FULL;
            while (n > 1) begin
               p = n >> 1;
               tree_marks[p] &= ~((n & 1) ? MARK_RIGHT : MARK_LEFT);
               if (tree_marks[p] != MARK_NONE) break;
               n = p;
            end
         end
      end
      return g;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      page_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_mode <= r.mode;
            req_request_pages <= r.pages;
            req_page_index <= r.index;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern plus a long hold-off on request
   logic hold_start = 1'b0;
   int   hold_left = 0, ready_phase = 0;
   always @(posedge clock) begin
      ready_phase <= ready_phase + 1;
      if (hold_start) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      if (hold_left > 0 || hold_start) rsp_ready <= 1'b0;
      else case ((ready_phase / 300) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      grant_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_grants.push_back(predict_grant({req_mode, req_request_pages,
                                                     req_page_index}));
            n_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               mismatches++;
               $display("ERROR %0t: response with nothing expected", $realtime);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_granted_page !== want.page)
                  report_mismatch("granted_page", int'(rsp_granted_page),
                                  int'(want.page));
               if (rsp_granted_pages !== want.pages)
                  report_mismatch("granted_pages", int'(rsp_granted_pages),
                                  int'(want.pages));
               if (want.status == STAT_DONE && want.pages != 0) n_grants++;
               else if (want.status == STAT_DONE) n_frees++;
               else n_rejects++;
            end
         end
      end
   end

   task automatic push_req(logic mode, int pages, int index);
      page_req_type r;
      r.mode = mode;
      r.pages = POOL_W'(pages);
      r.index = PAGE_W'(index);
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_grants.size() > 0);
   endtask

   task automatic write_pool(int value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= POOL_W'(value);
      @(posedge clock);
      csr_wen <= 1'b0;
      pool_size = value;
      rebuild_tree();
      live_pages.delete();
   endtask

   task automatic random_traffic(int count);
      int sel, pages;
      repeat (count) begin
         while (pending_reqs.size() > 1) @(posedge clock);
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            case ($urandom_range(0, 19))
               0: pages = $urandom_range(0, 2047);
               1, 2: pages = $urandom_range(129, 1024);
               3, 4, 5, 6, 7: pages = $urandom_range(1, 128);
               default: pages = $urandom_range(1, 8);
            endcase
            push_req(MODE_ALLOC, pages, $urandom_range(0, 1023));
         end else if (sel < 85 && live_pages.size() > 0) begin
            push_req(MODE_FREE, $urandom_range(0, 2047),
                     live_pages[$urandom_range(0, live_pages.size() - 1)]);
         end else begin
            push_req(MODE_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
         end
      end
   endtask

   int pools [6] = '{0, 1, 2047, 37, 700, 1024};

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      rebuild_tree();

      // directed: edges of the request fields, double free, misaligned free
      push_req(MODE_ALLOC, 0, 0);
      push_req(MODE_ALLOC, 1, 0);
      push_req(MODE_ALLOC, 2047, 0);
      push_req(MODE_ALLOC, 1024, 0);
      push_req(MODE_ALLOC, 3, 1023);
      push_req(MODE_FREE, 0, 1);
      push_req(MODE_FREE, 2047, 0);
      push_req(MODE_FREE, 0, 0);
      push_req(MODE_ALLOC, 512, 0);
      push_req(MODE_ALLOC, 512, 0);
      push_req(MODE_ALLOC, 1, 0);
      push_req(MODE_FREE, 0, 513);
      push_req(MODE_FREE, 0, 512);
      push_req(MODE_FREE, 0, 1023);
      push_req(MODE_FREE, 0, 0);
      push_req(MODE_ALLOC, 1024, 0);
      push_req(MODE_FREE, 0, 0);
      drain();
      random_traffic(340);
      drain();

      foreach (pools[i]) begin
         write_pool(pools[i]);
         push_req(MODE_ALLOC, 1, 0);
         push_req(MODE_ALLOC, 1024, 0);
         if (i == 2) begin
            // stall the response side while requests keep coming
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         random_traffic((pools[i] < 2) ? 30 : 130);
         drain();
      end

      repeat (200) @(posedge clock);
      $display("covered %0d requests over %0d pool sizes: %0d grants, %0d frees, %0d rejects",
               n_reqs, 7, n_grants, n_frees, n_rejects);
      if (mismatches == 0 && expected_grants.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  expected_grants.size());
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("timeout with %0d responses outstanding", expected_grants.size());
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
